### rtl/tqvg_pkg.sv
package tqvg_pkg;

    // default chunk side in tiles
    localparam int CHUNK_SIDE_DEF = 16;

    // field widths of the input item
    localparam int CHUNK_W = 6;
    localparam int SLOT_W  = 8;
    localparam int TEX_W   = 8;
    localparam int DEPTH_W = 4;

    // packed vertex layout
    localparam int POS_W     = 10;
    localparam int VTX_W     = 32;
    localparam int X_SHIFT   = 22;
    localparam int Y_SHIFT   = 12;
    localparam int Z_SHIFT   = 8;
    localparam int NUM_CORNER = 4;

    // reciprocal scale for the slot split
    localparam int DIV_SHIFT = 16;
    localparam int RECIP_W   = DIV_SHIFT + 1;

    // atlas offset added to the texture index at each corner
    localparam logic [TEX_W-1:0] ATLAS_ADD [NUM_CORNER] = '{8'd0, 8'd16, 8'd17, 8'd1};

    // one map tile as it enters the block
    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_x;
        logic [CHUNK_W-1:0] chunk_y;
        logic [SLOT_W-1:0]  tile_slot;
        logic [TEX_W-1:0]   texture_index;
        logic [DEPTH_W-1:0] depth;
        logic               flip_horizontal;
        logic               flip_vertical;
        logic               rotate_left;
        logic               rotate_right;
    } t_tile;

    // tile origin in map coordinates
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_coord;

    // four packed vertices and the empty flag
    typedef struct packed {
        logic [NUM_CORNER-1:0][VTX_W-1:0] corner;
        logic                             is_empty;
    } t_quad;

endpackage

### rtl/tqvg_if.sv
// tile channel into the block
interface tqvg_tile_if;
    logic                          valid;
    logic                          ready;
    logic [tqvg_pkg::CHUNK_W-1:0]  chunk_x;
    logic [tqvg_pkg::CHUNK_W-1:0]  chunk_y;
    logic [tqvg_pkg::SLOT_W-1:0]   tile_slot;
    logic [tqvg_pkg::TEX_W-1:0]    texture_index;
    logic [tqvg_pkg::DEPTH_W-1:0]  depth;
    logic                          flip_horizontal;
    logic                          flip_vertical;
    logic                          rotate_left;
    logic                          rotate_right;

    modport source (
        output valid, chunk_x, chunk_y, tile_slot, texture_index, depth,
               flip_horizontal, flip_vertical, rotate_left, rotate_right,
        input  ready
    );
    modport sink (
        input  valid, chunk_x, chunk_y, tile_slot, texture_index, depth,
               flip_horizontal, flip_vertical, rotate_left, rotate_right,
        output ready
    );
endinterface

// quad channel out of the block
interface tqvg_quad_if;
    logic                        valid;
    logic                        ready;
    logic [tqvg_pkg::VTX_W-1:0]  corner_0;
    logic [tqvg_pkg::VTX_W-1:0]  corner_1;
    logic [tqvg_pkg::VTX_W-1:0]  corner_2;
    logic [tqvg_pkg::VTX_W-1:0]  corner_3;
    logic                        is_empty;

    modport source (
        output valid, corner_0, corner_1, corner_2, corner_3, is_empty,
        input  ready
    );
    modport sink (
        input  valid, corner_0, corner_1, corner_2, corner_3, is_empty,
        output ready
    );
endinterface

### rtl/tqvg_coord.sv
module tqvg_coord #(
    parameter int CHUNK_SIDE = tqvg_pkg::CHUNK_SIDE_DEF
) (
    input  tqvg_pkg::t_tile  i_tile,
    output tqvg_pkg::t_coord o_coord
);

    localparam int SLOT_W    = tqvg_pkg::SLOT_W;
    localparam int RECIP_W   = tqvg_pkg::RECIP_W;
    localparam int DIV_SHIFT = tqvg_pkg::DIV_SHIFT;
    localparam int POS_W     = tqvg_pkg::POS_W;
    localparam int PROD_W    = SLOT_W + RECIP_W;
    localparam int WIDE_W    = 16;

    // rounded-up reciprocal of the side, exact for any 8-bit slot
    localparam int RECIP_VAL = ((2 ** DIV_SHIFT) + CHUNK_SIDE - 1) / CHUNK_SIDE;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam logic [WIDE_W-1:0]  SIDE  = WIDE_W'(CHUNK_SIDE);

    logic [PROD_W-1:0] w_prod;
    logic [SLOT_W-1:0] w_row;
    logic [WIDE_W-1:0] w_row_base;
    logic [WIDE_W-1:0] w_col;
    logic [WIDE_W-1:0] w_x;
    logic [WIDE_W-1:0] w_y;

    // row = slot / side by reciprocal, column = slot - row * side
    assign w_prod     = PROD_W'(i_tile.tile_slot) * PROD_W'(RECIP);
    assign w_row      = w_prod[DIV_SHIFT +: SLOT_W];
    assign w_row_base = WIDE_W'(w_row) * SIDE;
    assign w_col      = WIDE_W'(i_tile.tile_slot) - w_row_base;

    // map origin, wrapped to the position field
    assign w_x = WIDE_W'(i_tile.chunk_x) * SIDE + w_col;
    assign w_y = WIDE_W'(i_tile.chunk_y) * SIDE + WIDE_W'(w_row);

    assign o_coord.x = w_x[POS_W-1:0];
    assign o_coord.y = w_y[POS_W-1:0];

endmodule

### rtl/tqvg_corner.sv
module tqvg_corner (
    input  tqvg_pkg::t_tile  i_tile,
    input  tqvg_pkg::t_coord i_coord,
    output tqvg_pkg::t_quad  o_quad
);

    localparam int POS_W = tqvg_pkg::POS_W;
    localparam int NC    = tqvg_pkg::NUM_CORNER;

    logic [NC-1:0][POS_W-1:0] w_px;
    logic [NC-1:0][POS_W-1:0] w_py;
    logic [POS_W-1:0]         w_x1;
    logic [POS_W-1:0]         w_y1;

    assign w_x1 = i_coord.x + POS_W'(1);
    assign w_y1 = i_coord.y + POS_W'(1);

    // base corners, then flips and rotations in order
    always_comb begin
        w_px = {w_x1, w_x1, i_coord.x, i_coord.x};
        w_py = {w_y1, i_coord.y, i_coord.y, w_y1};
        if (i_tile.flip_horizontal) begin
            w_px = {w_px[0], w_px[1], w_px[2], w_px[3]};
        end
        if (i_tile.flip_vertical) begin
            w_py = {w_py[2], w_py[3], w_py[0], w_py[1]};
        end
        // counter-clockwise: corner k takes corner k-1
        if (i_tile.rotate_left) begin
            w_px = {w_px[2], w_px[1], w_px[0], w_px[3]};
            w_py = {w_py[2], w_py[1], w_py[0], w_py[3]};
        end
        // clockwise: corner k takes corner k+1
        if (i_tile.rotate_right) begin
            w_px = {w_px[0], w_px[3], w_px[2], w_px[1]};
            w_py = {w_py[0], w_py[3], w_py[2], w_py[1]};
        end
    end

    // pack vertices, zeros for an empty tile
    always_comb begin
        o_quad.is_empty = (i_tile.texture_index == '0);
        for (int k = 0; k < NC; k++) begin
            if (o_quad.is_empty) begin
                o_quad.corner[k] = '0;
            end else begin
                o_quad.corner[k] = {w_px[k], w_py[k], i_tile.depth,
                                    i_tile.texture_index + tqvg_pkg::ATLAS_ADD[k]};
            end
        end
    end

endmodule

### rtl/tile_quad_vertex_generator_top.sv
// tile quad vertex generator
// the quad comes out of the result register, loaded from the input register
// throughput: one tile per cycle, set by the input and result registers
// a held-off output stalls both registers; input ready drops once both are full
// reset: synchronous active low, clears both valid flags; payload not reset
module tile_quad_vertex_generator_top #(
    parameter int CHUNK_SIDE = tqvg_pkg::CHUNK_SIDE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tqvg_tile_if.sink    i_tile,
    tqvg_quad_if.source  o_quad
);

    logic             r_in_valid;
    logic             n_in_valid;
    tqvg_pkg::t_tile  r_tile;
    logic             r_out_valid;
    logic             n_out_valid;
    tqvg_pkg::t_quad  r_quad;
    tqvg_pkg::t_tile  w_tile_in;
    tqvg_pkg::t_coord w_coord;
    tqvg_pkg::t_quad  w_quad;
    logic             w_out_adv;
    logic             w_in_take;

    // handshake control
    assign w_out_adv    = !r_out_valid || o_quad.ready;
    assign i_tile.ready = !r_in_valid || w_out_adv;
    assign w_in_take    = i_tile.valid && i_tile.ready;
    assign n_in_valid   = i_tile.ready ? i_tile.valid : r_in_valid;
    assign n_out_valid  = w_out_adv ? r_in_valid : r_out_valid;

    // gather input item
    assign w_tile_in.chunk_x         = i_tile.chunk_x;
    assign w_tile_in.chunk_y         = i_tile.chunk_y;
    assign w_tile_in.tile_slot       = i_tile.tile_slot;
    assign w_tile_in.texture_index   = i_tile.texture_index;
    assign w_tile_in.depth           = i_tile.depth;
    assign w_tile_in.flip_horizontal = i_tile.flip_horizontal;
    assign w_tile_in.flip_vertical   = i_tile.flip_vertical;
    assign w_tile_in.rotate_left     = i_tile.rotate_left;
    assign w_tile_in.rotate_right    = i_tile.rotate_right;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_tile <= w_tile_in;
        end
    end

    tqvg_coord #(
        .CHUNK_SIDE (CHUNK_SIDE)
    ) u_coord (
        .i_tile  (r_tile),
        .o_coord (w_coord)
    );

    tqvg_corner u_corner (
        .i_tile  (r_tile),
        .i_coord (w_coord),
        .o_quad  (w_quad)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_out_adv) begin
            r_quad <= w_quad;
        end
    end

    assign o_quad.valid    = r_out_valid;
    assign o_quad.corner_0 = r_quad.corner[0];
    assign o_quad.corner_1 = r_quad.corner[1];
    assign o_quad.corner_2 = r_quad.corner[2];
    assign o_quad.corner_3 = r_quad.corner[3];
    assign o_quad.is_empty = r_quad.is_empty;

    // empty tile gives all-zero vertices
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_quad.is_empty |-> r_quad.corner == '0)
        else $error("empty tile with nonzero vertex");

    // atlas offsets stay tied to their corners
    a_atlas_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_quad.is_empty |->
            r_quad.corner[1][7:0] == r_quad.corner[0][7:0] + 8'd16 &&
            r_quad.corner[2][7:0] == r_quad.corner[0][7:0] + 8'd17 &&
            r_quad.corner[3][7:0] == r_quad.corner[0][7:0] + 8'd1)
        else $error("atlas offsets out of place");

    // an item held in the input register is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_adv |=> r_in_valid && $stable(r_tile))
        else $error("stalled tile lost");

    // a result is only loaded from a valid input stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid && w_out_adv |=> !r_out_valid)
        else $error("result without a source tile");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int SIDE        = tqvg_pkg::CHUNK_SIDE_DEF;
    localparam int CHUNK_W     = tqvg_pkg::CHUNK_W;
    localparam int SLOT_W      = tqvg_pkg::SLOT_W;
    localparam int TEX_W       = tqvg_pkg::TEX_W;
    localparam int DEPTH_W     = tqvg_pkg::DEPTH_W;
    localparam int POS_W       = tqvg_pkg::POS_W;
    localparam int NUM_CORNER  = tqvg_pkg::NUM_CORNER;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_LEN    = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;

    typedef tqvg_pkg::t_tile t_tile;
    typedef tqvg_pkg::t_quad t_quad;

    // atlas step per corner, corner 0 first
    localparam logic [TEX_W-1:0] CORNER_ATLAS_STEP [NUM_CORNER] = '{8'd0, 8'd16, 8'd17, 8'd1};

    // one row of the directed table; quad only holds a value when typed is set
    typedef struct packed {
        t_tile tile;
        logic  typed;
        t_quad quad;
    } t_tile_row;

    localparam int DIRECTED_N = 22;

    // tile fields: chunk_x, chunk_y, slot, texture, depth, fh, fv, rl, rr
    // quad fields: corners 3 down to 0, then the empty flag
    localparam t_tile_row DIRECTED_ROWS [DIRECTED_N] = '{
        // origin tile, plain orientation
        '{'{6'd0, 6'd0, 8'd0, 8'd1, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{'{32'h0040_1002, 32'h0040_0012, 32'h0000_0011, 32'h0000_1001}, 1'b0}},
        // empty tile with every other field at its top
        '{'{6'd63, 6'd63, 8'd255, 8'd0, 4'd15, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{'{4{32'h0}}, 1'b1}},
        // empty tile with every field at zero
        '{'{6'd0, 6'd0, 8'd0, 8'd0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{'{4{32'h0}}, 1'b1}},
        // far corner of the map: x, y and atlas all wrap
        '{'{6'd63, 6'd63, 8'd255, 8'd255, 4'd15, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{'{32'h0000_0F00, 32'h003F_FF10, 32'hFFFF_FF0F, 32'hFFC0_0FFF}, 1'b0}},
        // every orientation combination, both rotations together included
        '{'{6'd5, 6'd9, 8'h37, 8'h20, 4'd7, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{6'd5, 6'd9, 8'h48, 8'h21, 4'd7, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{6'd5, 6'd9, 8'h59, 8'h22, 4'd6, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{6'd5, 6'd9, 8'h6A, 8'h23, 4'd6, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{6'd12, 6'd3, 8'h7B, 8'h24, 4'd5, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{6'd12, 6'd3, 8'h8C, 8'h25, 4'd5, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{6'd12, 6'd3, 8'h9D, 8'h26, 4'd4, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{6'd12, 6'd3, 8'hAE, 8'h27, 4'd4, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{6'd42, 6'd21, 8'hBF, 8'h28, 4'd3, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{6'd42, 6'd21, 8'hC0, 8'h29, 4'd3, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{6'd42, 6'd21, 8'hD1, 8'h2A, 4'd2, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{6'd42, 6'd21, 8'hE2, 8'h2B, 4'd2, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{6'd31, 6'd62, 8'hF3, 8'h2C, 4'd1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{6'd31, 6'd62, 8'h04, 8'h2D, 4'd1, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{6'd31, 6'd62, 8'h15, 8'h2E, 4'd9, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{6'd31, 6'd62, 8'h26, 8'h2F, 4'd9, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        // atlas wrap on the upper corners, x, then y, at the top of its range
        '{'{6'd63, 6'd0, 8'h0F, 8'hF0, 4'd8, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{6'd0, 6'd63, 8'hF0, 8'hEF, 4'd3, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    tqvg_tile_if tile_if ();
    tqvg_quad_if quad_if ();

    tile_quad_vertex_generator_top #(
        .CHUNK_SIDE (SIDE)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tile  (tile_if),
        .o_quad  (quad_if)
    );

    t_quad quad_expected [$];
    int    fail_count   = 0;
    int    cycle_count  = 0;
    bit    src_idle     = 1'b1;
    bit    sink_idle    = 1'b1;
    int    hold_request = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // four packed vertices of one tile
    function automatic t_quad predict_quad(input t_tile t);
        t_quad            q;
        logic [POS_W-1:0] ox, oy, tmp;
        logic [POS_W-1:0] px [NUM_CORNER];
        logic [POS_W-1:0] py [NUM_CORNER];
        logic [POS_W-1:0] nx [NUM_CORNER];
        logic [POS_W-1:0] ny [NUM_CORNER];
        logic [TEX_W-1:0] atlas;
        q = '0;
        if (t.texture_index == '0) begin
            q.is_empty = 1'b1;
            return q;
        end
        ox = POS_W'(int'(t.chunk_x) * SIDE + int'(t.tile_slot) % SIDE);
        oy = POS_W'(int'(t.chunk_y) * SIDE + int'(t.tile_slot) / SIDE);
        px[0] = ox;      py[0] = oy + 1'b1;
        px[1] = ox;      py[1] = oy;
        px[2] = ox + 1'b1; py[2] = oy;
        px[3] = ox + 1'b1; py[3] = oy + 1'b1;
        // mirror x: swap corners 0/3 and 1/2
        if (t.flip_horizontal) begin
            tmp = px[0]; px[0] = px[3]; px[3] = tmp;
            tmp = px[1]; px[1] = px[2]; px[2] = tmp;
        end
        // mirror y: swap corners 0/1 and 2/3
        if (t.flip_vertical) begin
            tmp = py[0]; py[0] = py[1]; py[1] = tmp;
            tmp = py[2]; py[2] = py[3]; py[3] = tmp;
        end
        // counter-clockwise: corner k takes position of corner k-1
        if (t.rotate_left) begin
            for (int k = 0; k < NUM_CORNER; k++) begin
                nx[k] = px[(k + 3) % NUM_CORNER];
                ny[k] = py[(k + 3) % NUM_CORNER];
            end
            px = nx;
            py = ny;
        end
        // clockwise: corner k takes position of corner k+1
        if (t.rotate_right) begin
            for (int k = 0; k < NUM_CORNER; k++) begin
                nx[k] = px[(k + 1) % NUM_CORNER];
                ny[k] = py[(k + 1) % NUM_CORNER];
            end
            px = nx;
            py = ny;
        end
        for (int k = 0; k < NUM_CORNER; k++) begin
            atlas = t.texture_index + CORNER_ATLAS_STEP[k];
            q.corner[k] = {px[k], py[k], t.depth, atlas};
        end
        return q;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // random tile, some empty and some near the atlas wrap
    function automatic t_tile random_tile();
        t_tile t;
        int    roll;
        t.chunk_x         = CHUNK_W'($urandom);
        t.chunk_y         = CHUNK_W'($urandom);
        t.tile_slot       = SLOT_W'($urandom);
        t.depth           = DEPTH_W'($urandom);
        t.flip_horizontal = 1'($urandom);
        t.flip_vertical   = 1'($urandom);
        t.rotate_left     = 1'($urandom);
        t.rotate_right    = 1'($urandom);
        roll = $urandom_range(0, 9);
        if (roll == 0)
            t.texture_index = '0;
        else if (roll == 1)
            t.texture_index = TEX_W'($urandom_range(239, 255));
        else
            t.texture_index = TEX_W'($urandom_range(1, 255));
        return t;
    endfunction

    // offer one tile from a falling edge, return at the falling edge after it is taken
    task automatic send_tile(input t_tile t, input t_quad want);
        int gap;
        gap = pick_gap(src_idle);
        if (gap > 0) begin
            tile_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tile_if.chunk_x         = t.chunk_x;
        tile_if.chunk_y         = t.chunk_y;
        tile_if.tile_slot       = t.tile_slot;
        tile_if.texture_index   = t.texture_index;
        tile_if.depth           = t.depth;
        tile_if.flip_horizontal = t.flip_horizontal;
        tile_if.flip_vertical   = t.flip_vertical;
        tile_if.rotate_left     = t.rotate_left;
        tile_if.rotate_right    = t.rotate_right;
        tile_if.valid           = 1'b1;
        do @(posedge i_clk); while (!tile_if.ready);
        quad_expected.push_back(want);
        @(negedge i_clk);
    endtask

    // stop offering and let every pending quad come out
    task automatic drain_quads();
        tile_if.valid = 1'b0;
        while (quad_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // quad receiver: random stalls, plus a long hold when asked
    initial begin
        int wait_left;
        wait_left = 0;
        quad_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                wait_left    = hold_request;
                hold_request = 0;
            end
            if (!i_rst_n) begin
                quad_if.ready = 1'b0;
            end else if (wait_left > 0) begin
                quad_if.ready = 1'b0;
                wait_left--;
            end else begin
                quad_if.ready = 1'b1;
                wait_left = pick_gap(sink_idle);
            end
        end
    end

    // quad checker
    always @(posedge i_clk) begin
        t_quad got, want;
        if (i_rst_n && quad_if.valid && quad_if.ready) begin
            got.corner[0] = quad_if.corner_0;
            got.corner[1] = quad_if.corner_1;
            got.corner[2] = quad_if.corner_2;
            got.corner[3] = quad_if.corner_3;
            got.is_empty  = quad_if.is_empty;
            if (quad_expected.size() == 0) begin
                $error("quad with no tile pending: %h", got);
                fail_count++;
            end else begin
                want = quad_expected.pop_front();
                for (int k = 0; k < NUM_CORNER; k++) begin
                    if (got.corner[k] !== want.corner[k]) begin
                        $error("corner_%0d: expected %h, got %h", k, want.corner[k],
                               got.corner[k]);
                        fail_count++;
                    end
                end
                if (got.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d quads pending", cycle_count,
                   quad_expected.size());
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_tile t;
        tile_if.valid           = 1'b0;
        tile_if.chunk_x         = '0;
        tile_if.chunk_y         = '0;
        tile_if.tile_slot       = '0;
        tile_if.texture_index   = '0;
        tile_if.depth           = '0;
        tile_if.flip_horizontal = 1'b0;
        tile_if.flip_vertical   = 1'b0;
        tile_if.rotate_left     = 1'b0;
        tile_if.rotate_right    = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_N; i++) begin
            if (DIRECTED_ROWS[i].typed)
                send_tile(DIRECTED_ROWS[i].tile, DIRECTED_ROWS[i].quad);
            else
                send_tile(DIRECTED_ROWS[i].tile, predict_quad(DIRECTED_ROWS[i].tile));
        end
        drain_quads();

        // random phases: both idle, none idle, sender only, receiver only
        for (int p = 0; p < PHASES; p++) begin
            src_idle  = (p == 0) || (p == 2);
            sink_idle = (p == 0) || (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold while tiles keep coming
                if (n == 60)
                    hold_request = HOLD_LEN;
                t = random_tile();
                send_tile(t, predict_quad(t));
            end
            drain_quads();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### tile_quad_vertex_generator_top.f
rtl/tqvg_pkg.sv
rtl/tqvg_if.sv
rtl/tqvg_coord.sv
rtl/tqvg_corner.sv
rtl/tile_quad_vertex_generator_top.sv
sim/tb_top.sv
